[rtl/dfps_pkg.sv]
// ----------------------------------------------------------------------------
// dfps_pkg - shared types and constants of the feeder pump sequencer
// Phase codes, register indexes, count widths and the register file bundle.
// ----------------------------------------------------------------------------
package dfps_pkg;

	localparam int SLOT_COUNT = 6;
	localparam int COUNT_BITS = 20;

	localparam int FIELD_BITS = 20;
	localparam int WIDE_BITS  = 3 * FIELD_BITS;
	localparam int SLOT_BITS  = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int SAT_BITS   = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [FIELD_BITS-1:0] field_t;
	typedef logic [WIDE_BITS-1:0]  wide_t;
	typedef logic [SLOT_BITS-1:0]  slot_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

	typedef enum logic [2:0] {
		PH_WPRIME = 3'd0,
		PH_PAUSE  = 3'd1,
		PH_FPRIME = 3'd2,
		PH_FEED   = 3'd3,
		PH_UV     = 3'd4,
		PH_WASH   = 3'd5,
		PH_DARK   = 3'd6,
		PH_START  = 3'd7
	} phase_t;

	localparam cfg_idx_t REG_FEEDING     = 4'd0;
	localparam cfg_idx_t REG_WASH        = 4'd1;
	localparam cfg_idx_t REG_DARK_WAIT   = 4'd2;
	localparam cfg_idx_t REG_WASH_PRIME  = 4'd3;
	localparam cfg_idx_t REG_PRIME_PAUSE = 4'd4;
	localparam cfg_idx_t REG_FEED_PRIME  = 4'd5;
	localparam cfg_idx_t REG_ON_ODD      = 4'd6;
	localparam cfg_idx_t REG_ON_EVEN     = 4'd7;

	typedef struct packed {
		field_t feeding;
		field_t wash;
		field_t dark_wait;
		field_t wash_prime;
		field_t prime_pause;
		field_t feed_prime;
		wide_t  on_odd;
		wide_t  on_even;
	} dfps_cfg_t;

	typedef struct packed {
		logic   feed_pump_one;
		logic   feed_pump_two;
		logic   uv_lamp_one;
		logic   uv_lamp_two;
		logic   rinse_pump_one;
		logic   rinse_pump_two;
		logic   red_indicator;
		logic   green_indicator;
		slot_t  slot_number;
		phase_t phase_code;
	} dfps_drive_t;

	// Phase length: saturate to the counter, and never less than one tick.
	function automatic count_t ticks_of(field_t n);
		logic [SAT_BITS-1:0] w;
		logic [SAT_BITS-1:0] cap;
		w   = SAT_BITS'(n);
		cap = SAT_BITS'({COUNT_BITS{1'b1}});
		if (w > cap) w = cap;
		if (w == '0) w = SAT_BITS'(1);
		return COUNT_BITS'(w);
	endfunction

endpackage

[rtl/dfps_ifs.sv]
// ----------------------------------------------------------------------------
// dfps_ifs - channel interfaces of the feeder pump sequencer
// Tick input, drive output and register write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface dfps_tick_if;
	logic valid;
	logic ready;
	logic light_present;

	modport source (output valid, output light_present, input ready);
	modport sink (input valid, input light_present, output ready);
endinterface

interface dfps_drive_if import dfps_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       feed_pump_one;
	logic       feed_pump_two;
	logic       uv_lamp_one;
	logic       uv_lamp_two;
	logic       rinse_pump_one;
	logic       rinse_pump_two;
	logic       red_indicator;
	logic       green_indicator;
	logic [2:0] slot_number;
	logic [2:0] phase_code;

	modport source (output valid, output feed_pump_one, output feed_pump_two,
		output uv_lamp_one, output uv_lamp_two, output rinse_pump_one,
		output rinse_pump_two, output red_indicator, output green_indicator,
		output slot_number, output phase_code, input ready);
	modport sink (input valid, input feed_pump_one, input feed_pump_two,
		input uv_lamp_one, input uv_lamp_two, input rinse_pump_one,
		input rinse_pump_two, input red_indicator, input green_indicator,
		input slot_number, input phase_code, output ready);
endinterface

interface dfps_cfg_if import dfps_pkg::*; ();
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	wide_t    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/dfps_regs.sv]
// ----------------------------------------------------------------------------
// dfps_regs - register file of the feeder pump sequencer
// Takes register write transactions and holds the phase counts and on-times.
// ----------------------------------------------------------------------------
module dfps_regs import dfps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dfps_cfg_if.sink   cfg,
	output dfps_cfg_t  regs
);

	dfps_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.feeding     <= FIELD_BITS'(600);
			regs_q.wash        <= FIELD_BITS'(300);
			regs_q.dark_wait   <= FIELD_BITS'(3600);
			regs_q.wash_prime  <= FIELD_BITS'(60);
			regs_q.prime_pause <= FIELD_BITS'(1);
			regs_q.feed_prime  <= FIELD_BITS'(60);
			regs_q.on_odd      <= '0;
			regs_q.on_even     <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FEEDING:     regs_q.feeding     <= cfg.data[FIELD_BITS-1:0];
				REG_WASH:        regs_q.wash        <= cfg.data[FIELD_BITS-1:0];
				REG_DARK_WAIT:   regs_q.dark_wait   <= cfg.data[FIELD_BITS-1:0];
				REG_WASH_PRIME:  regs_q.wash_prime  <= cfg.data[FIELD_BITS-1:0];
				REG_PRIME_PAUSE: regs_q.prime_pause <= cfg.data[FIELD_BITS-1:0];
				REG_FEED_PRIME:  regs_q.feed_prime  <= cfg.data[FIELD_BITS-1:0];
				REG_ON_ODD:      regs_q.on_odd      <= cfg.data;
				REG_ON_EVEN:     regs_q.on_even     <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

[rtl/dual_feeder_pump_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// dual_feeder_pump_sequencer_unit - timing sequencer for a two-feeder pump rig
// Steps prime stages and a loop of feeder slots, one drive word per tick.
// ----------------------------------------------------------------------------
// Usage:
//   tick  : one transaction per time tick, carrying the light sensor bit.
//   drive : one transaction per tick with every pump, lamp and LED line,
//           plus the current slot and phase code.
//   cfg   : register writes, always ready; a count is read on the first
//           tick of its phase, so a write applies from the next phase.
// The drive word for a tick is registered at the edge that takes the tick.
// Throughput is one tick per cycle while drive.ready holds, set by the single
// phase/slot/countdown register update done in that same cycle.
// A new tick is taken while the output register is empty or being emptied,
// so a stalled receiver holds the drive word and backpressures tick.ready.
// Reset starts the wash prime stage at slot 0 with the output empty and
// restores the register defaults.
// ----------------------------------------------------------------------------
module dual_feeder_pump_sequencer_unit import dfps_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	dfps_tick_if.sink    tick,
	dfps_drive_if.source drive,
	dfps_cfg_if.sink     cfg
);

	dfps_cfg_t   regs;
	phase_t      phase_q, cur_phase, nxt_phase;
	slot_t       slot_q, nxt_slot;
	count_t      rem_q, cur_rem, load_rem, left;
	field_t      dur_sel, on_time;
	wide_t       on_reg;
	logic [SLOT_BITS:0] slot_inc;
	logic        two;
	logic        take;
	logic        valid_q;
	dfps_drive_t res, drive_s1;

	dfps_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	assign tick.ready = !valid_q || drive.ready;
	assign take       = tick.valid && tick.ready;

	always_comb begin
		cur_phase = phase_q;
		cur_rem   = rem_q;
		if (phase_q == PH_START) begin
			cur_phase = tick.light_present ? PH_FEED : PH_DARK;
			cur_rem   = '0;
		end

		// Slots alternate registers; slots past the third pair have no field.
		on_reg = slot_q[0] ? regs.on_even : regs.on_odd;
		case (slot_q[SLOT_BITS-1:1])
			2'd0:    on_time = on_reg[FIELD_BITS-1:0];
			2'd1:    on_time = on_reg[2*FIELD_BITS-1:FIELD_BITS];
			2'd2:    on_time = on_reg[3*FIELD_BITS-1:2*FIELD_BITS];
			default: on_time = '0;
		endcase

		case (cur_phase)
			PH_WPRIME: dur_sel = regs.wash_prime;
			PH_PAUSE:  dur_sel = regs.prime_pause;
			PH_FPRIME: dur_sel = regs.feed_prime;
			PH_FEED:   dur_sel = regs.feeding;
			PH_UV:     dur_sel = on_time;
			PH_WASH:   dur_sel = regs.wash;
			default:   dur_sel = regs.dark_wait;
		endcase

		load_rem = (cur_rem == '0) ? ticks_of(dur_sel) : cur_rem;
		left     = load_rem - COUNT_BITS'(1);

		two = slot_q[0];
		res = '0;
		case (cur_phase)
			PH_WPRIME: begin
				res.rinse_pump_one  = 1'b1;
				res.rinse_pump_two  = 1'b1;
				res.red_indicator   = 1'b1;
				res.green_indicator = 1'b1;
			end
			PH_FPRIME: begin
				res.feed_pump_one   = 1'b1;
				res.feed_pump_two   = 1'b1;
				res.red_indicator   = 1'b1;
				res.green_indicator = 1'b1;
			end
			PH_FEED: begin
				res.feed_pump_one   = !two;
				res.uv_lamp_one     = !two;
				res.red_indicator   = !two;
				res.feed_pump_two   = two;
				res.uv_lamp_two     = two;
				res.green_indicator = two;
			end
			PH_UV: begin
				res.uv_lamp_one = !two;
				res.uv_lamp_two = two;
			end
			PH_WASH: begin
				res.rinse_pump_one  = !two;
				res.rinse_pump_two  = two;
				res.red_indicator   = 1'b1;
				res.green_indicator = 1'b1;
			end
			default: ;
		endcase
		res.slot_number = slot_q;
		res.phase_code  = cur_phase;

		slot_inc  = {1'b0, slot_q} + (SLOT_BITS+1)'(1);
		nxt_phase = cur_phase;
		nxt_slot  = slot_q;
		if (left == '0) begin
			case (cur_phase)
				PH_WPRIME: nxt_phase = PH_PAUSE;
				PH_PAUSE:  nxt_phase = PH_FPRIME;
				PH_FPRIME: begin
					nxt_phase = PH_START;
					nxt_slot  = '0;
				end
				PH_FEED:   nxt_phase = PH_UV;
				PH_UV:     nxt_phase = PH_WASH;
				default: begin
					// end of wash or dark wait: move to the next slot
					nxt_phase = PH_START;
					nxt_slot  = (slot_inc >= (SLOT_BITS+1)'(SLOT_COUNT)) ? '0 :
						slot_inc[SLOT_BITS-1:0];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WPRIME;
			slot_q  <= '0;
			rem_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= nxt_phase;
				slot_q  <= nxt_slot;
				rem_q   <= left;
			end
			if (take) valid_q <= 1'b1;
			else if (drive.ready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) drive_s1 <= res;
	end

	assign drive.valid           = valid_q;
	assign drive.feed_pump_one   = drive_s1.feed_pump_one;
	assign drive.feed_pump_two   = drive_s1.feed_pump_two;
	assign drive.uv_lamp_one     = drive_s1.uv_lamp_one;
	assign drive.uv_lamp_two     = drive_s1.uv_lamp_two;
	assign drive.rinse_pump_one  = drive_s1.rinse_pump_one;
	assign drive.rinse_pump_two  = drive_s1.rinse_pump_two;
	assign drive.red_indicator   = drive_s1.red_indicator;
	assign drive.green_indicator = drive_s1.green_indicator;
	assign drive.slot_number     = drive_s1.slot_number;
	assign drive.phase_code      = drive_s1.phase_code;

endmodule
